@@ hdl/rtis_pkg.sv @@
// ----------------------------------------------------------------------------
// Row table package
// Shared types, command and status codes, and default sizes for the row table.
// ----------------------------------------------------------------------------
`default_nettype none

package rtis_pkg;

   localparam int ROW_LIMIT_DEF  = 32;
   localparam int COL_LIMIT_DEF  = 32;
   localparam int DATA_WIDTH_DEF = 32;

   typedef logic [2:0]         cmd_type;
   typedef logic [5:0]         pos_type;
   typedef logic [4:0]         col_type;
   typedef logic signed [31:0] value_type;
   typedef logic [2:0]         status_type;
   typedef logic [5:0]         found_type;
   typedef logic [5:0]         count_type;
   typedef logic [5:0]         cfg_type;

   localparam cmd_type CMD_STAGE   = 3'd0;
   localparam cmd_type CMD_INSERT  = 3'd1;
   localparam cmd_type CMD_DELETE  = 3'd2;
   localparam cmd_type CMD_SEARCH  = 3'd3;
   localparam cmd_type CMD_AVERAGE = 3'd4;
   localparam cmd_type CMD_READ    = 3'd5;
   localparam cmd_type CMD_CLEAR   = 3'd6;

   localparam status_type ST_OK     = 3'd0;
   localparam status_type ST_FULL   = 3'd1;
   localparam status_type ST_EMPTY  = 3'd2;
   localparam status_type ST_BADPOS = 3'd3;
   localparam status_type ST_MISS   = 3'd4;

   localparam cfg_type COLS_RESET = 6'd1;

endpackage

`default_nettype wire

@@ hdl/rtis_if.sv @@
// ----------------------------------------------------------------------------
// Row table channel interfaces
// Command, response and column-count write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtis_req_if;
   import rtis_pkg::*;
   logic      valid;
   logic      ready;
   cmd_type   cmd;
   pos_type   position;
   col_type   column;
   value_type value;
   modport source (output valid, cmd, position, column, value, input ready);
   modport sink (input valid, cmd, position, column, value, output ready);
endinterface

interface rtis_rsp_if;
   import rtis_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   found_type  found_row;
   found_type  found_column;
   value_type  data_out;
   count_type  row_count;
   modport source (output valid, status, found_row, found_column, data_out, row_count,
                   input ready);
   modport sink (input valid, status, found_row, found_column, data_out, row_count,
                 output ready);
endinterface

interface rtis_csr_if;
   import rtis_pkg::*;
   logic    valid;
   logic    ready;
   cfg_type columns_in_use;
   modport source (output valid, columns_in_use, input ready);
   modport sink (input valid, columns_in_use, output ready);
endinterface

`default_nettype wire

@@ hdl/rtis_div.sv @@
// ----------------------------------------------------------------------------
// Row table divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rtis_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W+1:0] diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff, q_ff[NUM_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

@@ hdl/row_table_insert_delete_search.sv @@
// ----------------------------------------------------------------------------
// Row table with insert, delete, search and average
// Table of signed rows held in a synchronous memory, one command at a time.
// ----------------------------------------------------------------------------
// Commands arrive on req_if and each gives exactly one transaction on rsp_if.
// The column count is written on csr_if, which is always ready; the user must
// write it only while the block is idle, as the block does not enforce this.
// The table lives in a single-port-read memory walked one element per cycle;
// the staging row lives in a small memory of its own. Insert and delete move
// the table one element at a time, and insert then copies the staging row
// into the new row. Search stops at the first match. Average sums every
// element and, when rows*columns is nonzero, divides the sum by it in the divider.
// Reset empties the table, clears the staging row and sets one column; the
// table memory itself needs no clearing pass. A finished response waits in
// the output register while the receiver stalls; the next command is still
// accepted and its result waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module row_table_insert_delete_search #(
   parameter int ROW_LIMIT  = rtis_pkg::ROW_LIMIT_DEF,
   parameter int COL_LIMIT  = rtis_pkg::COL_LIMIT_DEF,
   parameter int DATA_WIDTH = rtis_pkg::DATA_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rtis_req_if.sink   req_if,
   rtis_rsp_if.source rsp_if,
   rtis_csr_if.sink   csr_if
);
   import rtis_pkg::*;

   localparam int RIW   = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;
   localparam int CIW   = (COL_LIMIT > 1) ? $clog2(COL_LIMIT) : 1;
   localparam int AW    = RIW + CIW;
   localparam int DEPTH = 1 << AW;
   localparam int SDEP  = 1 << CIW;
   localparam int RW    = $clog2(ROW_LIMIT + 1);
   localparam int CB    = $clog2(COL_LIMIT + 1);
   localparam int ELEMS = ROW_LIMIT * COL_LIMIT;
   localparam int DEN_W = $clog2(ELEMS + 1);
   localparam int SW    = DATA_WIDTH + DEN_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WALK = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]                   state_ff, state_in;
   cmd_type                      op_ff, op_in;
   logic [RW-1:0]                rows_ff, rows_in;
   cfg_type                      cols_ff, cols_in;
   logic [CB-1:0]                nc;
   logic [CB-1:0]                nc_m1;

   logic signed [DATA_WIDTH-1:0] tbl_mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] tbl_rdata_ff;
   logic [AW-1:0]                tbl_raddr;
   logic                         tbl_we;
   logic signed [DATA_WIDTH-1:0] tbl_wdata;

   logic signed [DATA_WIDTH-1:0] stg_mem [SDEP];
   logic signed [DATA_WIDTH-1:0] stg_rdata_ff;
   logic [SDEP-1:0]              stg_valid_ff, stg_valid_in;
   logic                         stg_we;
   logic [CIW-1:0]               stg_waddr;

   logic                         issuing_ff, issuing_in;
   logic                         stage_phase_ff, stage_phase_in;
   logic                         down_ff, down_in;
   logic [RIW-1:0]               row_ff, row_in;
   logic [RIW-1:0]               end_row_ff, end_row_in;
   logic [RIW-1:0]               ins_row_ff, ins_row_in;
   logic [CIW-1:0]               col_ff, col_in;
   logic                         p_valid_ff, p_valid_in;
   logic                         p_stage_ff, p_stage_in;
   logic [AW-1:0]                p_dst_ff, p_dst_in;
   logic [RIW-1:0]               p_row_ff, p_row_in;
   logic [CIW-1:0]               p_col_ff, p_col_in;
   logic                         hit_ff, hit_in;
   logic signed [DATA_WIDTH-1:0] target_ff, target_in;
   logic signed [SW-1:0]         sum_ff, sum_in;
   logic                         neg_ff, neg_in;
   logic [DEN_W-1:0]             den_ff, den_in;

   status_type                   res_status_ff, res_status_in;
   found_type                    res_frow_ff, res_frow_in;
   found_type                    res_fcol_ff, res_fcol_in;
   value_type                    res_data_ff, res_data_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   status_type                   rsp_status_ff, rsp_status_in;
   found_type                    rsp_frow_ff, rsp_frow_in;
   found_type                    rsp_fcol_ff, rsp_fcol_in;
   value_type                    rsp_data_ff, rsp_data_in;
   count_type                    rsp_count_ff, rsp_count_in;

   logic                         div_start;
   logic                         div_done;
   logic [SW-1:0]                div_num;
   logic [SW-1:0]                div_quot;

   logic [31:0]                  pos32;
   logic [31:0]                  col32;
   logic [31:0]                  rows32;
   logic [31:0]                  nc32;
   logic signed [DATA_WIDTH-1:0] req_elem;

   assign nc       = (32'(cols_ff) > COL_LIMIT) ? CB'(COL_LIMIT) : CB'(cols_ff);
   assign nc_m1    = nc - CB'(1);
   assign pos32    = 32'(req_if.position);
   assign col32    = 32'(req_if.column);
   assign rows32   = 32'(rows_ff);
   assign nc32     = 32'(nc);
   assign req_elem = DATA_WIDTH'(req_if.value);
   assign div_num  = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);

   rtis_div #(
      .NUM_W (SW),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      rows_in        = rows_ff;
      cols_in        = cols_ff;
      stg_valid_in   = stg_valid_ff;
      issuing_in     = issuing_ff;
      stage_phase_in = stage_phase_ff;
      down_in        = down_ff;
      row_in         = row_ff;
      end_row_in     = end_row_ff;
      ins_row_in     = ins_row_ff;
      col_in         = col_ff;
      p_valid_in     = 1'b0;
      p_stage_in     = p_stage_ff;
      p_dst_in       = p_dst_ff;
      p_row_in       = p_row_ff;
      p_col_in       = p_col_ff;
      hit_in         = hit_ff;
      target_in      = target_ff;
      sum_in         = sum_ff;
      neg_in         = neg_ff;
      den_in         = den_ff;
      res_status_in  = res_status_ff;
      res_frow_in    = res_frow_ff;
      res_fcol_in    = res_fcol_ff;
      res_data_in    = res_data_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_frow_in    = rsp_frow_ff;
      rsp_fcol_in    = rsp_fcol_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_count_in   = rsp_count_ff;
      tbl_raddr      = {row_ff, col_ff};
      tbl_we         = 1'b0;
      tbl_wdata      = p_stage_ff ? stg_rdata_ff : tbl_rdata_ff;
      stg_we         = 1'b0;
      stg_waddr      = CIW'(req_if.column);
      div_start      = 1'b0;

      if (csr_if.valid) begin
         cols_in = csr_if.columns_in_use;
      end
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            tbl_raddr = {RIW'(pos32 - 32'd1), CIW'(col32)};
            if (req_if.valid) begin
               op_in          = req_if.cmd;
               res_status_in  = ST_OK;
               res_frow_in    = '0;
               res_fcol_in    = '0;
               res_data_in    = '0;
               hit_in         = 1'b0;
               sum_in         = '0;
               target_in      = req_elem;
               issuing_in     = 1'b0;
               stage_phase_in = 1'b0;
               down_in        = 1'b0;
               col_in         = '0;
               row_in         = '0;
               end_row_in     = RIW'(rows32 - 32'd1);
               den_in         = DEN_W'(rows_ff) * DEN_W'(nc);
               state_in       = S_DONE;
               case (req_if.cmd)
                  CMD_STAGE: begin
                     if (col32 < COL_LIMIT) begin
                        stg_we = 1'b1;
                        stg_valid_in[stg_waddr] = 1'b1;
                     end else begin
                        res_status_in = ST_BADPOS;
                     end
                  end
                  CMD_INSERT: begin
                     if (pos32 < 32'd1 || pos32 > rows32 + 32'd1) begin
                        res_status_in = ST_BADPOS;
                     end else if (rows32 >= ROW_LIMIT) begin
                        res_status_in = ST_FULL;
                     end else begin
                        state_in   = S_WALK;
                        ins_row_in = RIW'(pos32 - 32'd1);
                        issuing_in = (nc != '0);
                        end_row_in = RIW'(pos32 - 32'd1);
                        down_in    = 1'b1;
                        if (pos32 - 32'd1 == rows32) begin
                           stage_phase_in = 1'b1;
                        end else begin
                           row_in = RIW'(rows32 - 32'd1);
                        end
                     end
                  end
                  CMD_DELETE: begin
                     if (rows32 == 32'd0) begin
                        res_status_in = ST_EMPTY;
                     end else if (pos32 < 32'd1 || pos32 > rows32) begin
                        res_status_in = ST_BADPOS;
                     end else begin
                        state_in   = S_WALK;
                        issuing_in = (nc != '0) && (pos32 < rows32);
                        row_in     = RIW'(pos32);
                     end
                  end
                  CMD_SEARCH, CMD_AVERAGE: begin
                     state_in   = S_WALK;
                     issuing_in = (nc != '0) && (rows32 != 32'd0);
                  end
                  CMD_READ: begin
                     if (pos32 < 32'd1 || pos32 > rows32 || col32 >= nc32) begin
                        res_status_in = ST_BADPOS;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  CMD_CLEAR: begin
                     rows_in      = '0;
                     stg_valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_READ: begin
            res_data_in = 32'(tbl_rdata_ff);
            state_in    = S_DONE;
         end

         S_WALK: begin
            if (issuing_ff) begin
               p_valid_in = 1'b1;
               p_stage_in = stage_phase_ff;
               p_row_in   = row_ff;
               p_col_in   = col_ff;
               if (stage_phase_ff) begin
                  p_dst_in = {ins_row_ff, col_ff};
               end else if (down_ff) begin
                  p_dst_in = {row_ff + RIW'(1), col_ff};
               end else begin
                  p_dst_in = {row_ff - RIW'(1), col_ff};
               end
               if (col_ff == CIW'(nc_m1)) begin
                  col_in = '0;
                  if (stage_phase_ff) begin
                     issuing_in = 1'b0;
                  end else if (row_ff == end_row_ff) begin
                     if (op_ff == CMD_INSERT) begin
                        stage_phase_in = 1'b1;
                     end else begin
                        issuing_in = 1'b0;
                     end
                  end else if (down_ff) begin
                     row_in = row_ff - RIW'(1);
                  end else begin
                     row_in = row_ff + RIW'(1);
                  end
               end else begin
                  col_in = col_ff + CIW'(1);
               end
            end

            if (p_valid_ff) begin
               case (op_ff)
                  CMD_INSERT, CMD_DELETE: begin
                     tbl_we = 1'b1;
                  end
                  CMD_SEARCH: begin
                     if (!hit_ff && tbl_rdata_ff == target_ff) begin
                        hit_in      = 1'b1;
                        issuing_in  = 1'b0;
                        res_frow_in = found_type'(32'(p_row_ff) + 32'd1);
                        res_fcol_in = found_type'(32'(p_col_ff) + 32'd1);
                     end
                  end
                  CMD_AVERAGE: begin
                     sum_in = sum_ff + SW'(tbl_rdata_ff);
                  end
                  default: begin
                  end
               endcase
            end

            if (!issuing_ff && !p_valid_ff) begin
               state_in = S_DONE;
               case (op_ff)
                  CMD_INSERT: begin
                     rows_in = rows_ff + RW'(1);
                  end
                  CMD_DELETE: begin
                     rows_in = rows_ff - RW'(1);
                  end
                  CMD_SEARCH: begin
                     if (!hit_ff) begin
                        res_status_in = ST_MISS;
                     end
                  end
                  CMD_AVERAGE: begin
                     if (den_ff != '0) begin
                        div_start = 1'b1;
                        neg_in    = sum_ff[SW-1];
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_DIV: begin
            if (div_done) begin
               res_data_in = neg_ff ? 32'(-div_quot) : 32'(div_quot);
               state_in    = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_frow_in   = res_frow_ff;
               rsp_fcol_in   = res_fcol_ff;
               rsp_data_in   = res_data_ff;
               rsp_count_in  = count_type'(rows_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_ff      <= '0;
         cols_ff      <= COLS_RESET;
         stg_valid_ff <= '0;
         issuing_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         stg_valid_ff <= stg_valid_in;
         issuing_ff   <= issuing_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      stage_phase_ff <= stage_phase_in;
      down_ff        <= down_in;
      row_ff         <= row_in;
      end_row_ff     <= end_row_in;
      ins_row_ff     <= ins_row_in;
      col_ff         <= col_in;
      p_stage_ff     <= p_stage_in;
      p_dst_ff       <= p_dst_in;
      p_row_ff       <= p_row_in;
      p_col_ff       <= p_col_in;
      hit_ff         <= hit_in;
      target_ff      <= target_in;
      sum_ff         <= sum_in;
      neg_ff         <= neg_in;
      den_ff         <= den_in;
      res_status_ff  <= res_status_in;
      res_frow_ff    <= res_frow_in;
      res_fcol_ff    <= res_fcol_in;
      res_data_ff    <= res_data_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_frow_ff    <= rsp_frow_in;
      rsp_fcol_ff    <= rsp_fcol_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[p_dst_ff] <= tbl_wdata;
      end
      tbl_rdata_ff <= tbl_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (stg_we) begin
         stg_mem[stg_waddr] <= req_elem;
      end
      stg_rdata_ff <= stg_valid_ff[col_ff] ? stg_mem[col_ff] : '0;
   end

   assign req_if.ready        = (state_ff == S_IDLE);
   assign csr_if.ready        = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.found_row    = rsp_frow_ff;
   assign rsp_if.found_column = rsp_fcol_ff;
   assign rsp_if.data_out     = rsp_data_ff;
   assign rsp_if.row_count    = rsp_count_ff;

endmodule

`default_nettype wire

@@ hdl/rtis_chk.sv @@
// ----------------------------------------------------------------------------
// Row table port checker
// Watches the row table's channels and flags illegal port behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module rtis_chk (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rtis_pkg::status_type rsp_status,
   input rtis_pkg::found_type  rsp_found_row,
   input rtis_pkg::found_type  rsp_found_column,
   input rtis_pkg::value_type  rsp_data_out
);
   import rtis_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Response transaction withdrawn while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_data_out)
                                  && $stable(rsp_found_row) && $stable(rsp_found_column))
      else $error("Response payload changed while stalled.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Command accepted while the previous one is still in work.");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_found_row == '0 && rsp_found_column == '0 && rsp_data_out == '0)
      else $error("Failed command returned nonzero result fields.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

endmodule

bind row_table_insert_delete_search rtis_chk u_rtis_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_status       (rsp_if.status),
   .rsp_found_row    (rsp_if.found_row),
   .rsp_found_column (rsp_if.found_column),
   .rsp_data_out     (rsp_if.data_out)
);

`default_nettype wire

@@ tb/sv/tb_row_table_insert_delete_search.sv @@
// ----------------------------------------------------------------------------
// Row table testbench
// Drives command transactions with random gaps and receiver stalls, predicts
// every response from a software image of the table, staging row and column
// count, and compares each response field by field in arrival order.
// ----------------------------------------------------------------------------

module tb_row_table_insert_delete_search;
   import rtis_pkg::*;

   localparam int ROWS = ROW_LIMIT_DEF;
   localparam int COLS = COL_LIMIT_DEF;
   localparam int IDLE_LIMIT = 20000;
   localparam cmd_type CMD_UNUSED = 3'd7;

   typedef struct packed {
      status_type status;
      found_type  found_row;
      found_type  found_column;
      value_type  data_out;
      count_type  row_count;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rtis_req_if req_if();
   rtis_rsp_if rsp_if();
   rtis_csr_if csr_if();

   row_table_insert_delete_search dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   value_type    row_mem [ROWS][COLS];
   bit           row_defined [ROWS][COLS];
   value_type    staged_row [COLS];
   int           rows_held_now = 0;
   cfg_type      cols_setting = COLS_RESET;
   response_type pending_responses [$];
   int           fail_count = 0;
   int           idle_cycles = 0;
   bit           quiet = 1'b0;

   function automatic int active_cols();
      return (cols_setting > COLS) ? COLS : int'(cols_setting);
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic value_type rand_value();
      int k;
      k = $urandom_range(0, 15);
      if (k == 0) return 32'sh7fffffff;
      if (k == 1) return 32'sh80000000;
      if (k == 2) return '0;
      if (k == 3) return '1;
      if (k < 8) return value_type'(int'($urandom_range(0, 16)) - 8);
      return value_type'($urandom);
   endfunction

   function automatic pos_type rand_pos();
      return pos_type'($urandom_range(0, 63));
   endfunction

   function automatic col_type rand_col();
      return col_type'($urandom_range(0, 31));
   endfunction

   function automatic void copy_row(int dst, int src, int nc);
      for (int j = 0; j < nc; j++) begin
         row_mem[dst][j] = row_mem[src][j];
         row_defined[dst][j] = row_defined[src][j];
      end
   endfunction

   function automatic response_type predict_response(cmd_type cmd, pos_type pos, col_type col,
                                                     value_type val);
      response_type rsp;
      int nc;
      int p;
      bit hit;
      longint sum;
      rsp = '0;
      rsp.status = ST_OK;
      nc = active_cols();
      p = int'(pos);
      case (cmd)
         CMD_STAGE: begin
            if (int'(col) < COLS) staged_row[col] = val;
            else rsp.status = ST_BADPOS;
         end
         CMD_INSERT: begin
            if (p < 1 || p > rows_held_now + 1) begin
               rsp.status = ST_BADPOS;
            end else if (rows_held_now >= ROWS) begin
               rsp.status = ST_FULL;
            end else begin
               for (int i = rows_held_now; i >= p; i--) copy_row(i, i - 1, nc);
               for (int j = 0; j < nc; j++) begin
                  row_mem[p - 1][j] = staged_row[j];
                  row_defined[p - 1][j] = 1'b1;
               end
               rows_held_now++;
            end
         end
         CMD_DELETE: begin
            if (rows_held_now == 0) begin
               rsp.status = ST_EMPTY;
            end else if (p < 1 || p > rows_held_now) begin
               rsp.status = ST_BADPOS;
            end else begin
               for (int i = p - 1; i + 1 < rows_held_now; i++) copy_row(i, i + 1, nc);
               rows_held_now--;
            end
         end
         CMD_SEARCH: begin
            hit = 1'b0;
            for (int i = 0; i < rows_held_now && !hit; i++) begin
               for (int j = 0; j < nc && !hit; j++) begin
                  if (row_mem[i][j] == val) begin
                     hit = 1'b1;
                     rsp.found_row = found_type'(i + 1);
                     rsp.found_column = found_type'(j + 1);
                  end
               end
            end
            if (!hit) rsp.status = ST_MISS;
         end
         CMD_AVERAGE: begin
            if (rows_held_now != 0 && nc != 0) begin
               sum = 0;
               for (int i = 0; i < rows_held_now; i++) begin
                  for (int j = 0; j < nc; j++) sum += longint'(row_mem[i][j]);
               end
               rsp.data_out = value_type'(sum / longint'(rows_held_now * nc));
            end
         end
         CMD_READ: begin
            if (p < 1 || p > rows_held_now || int'(col) >= nc) rsp.status = ST_BADPOS;
            else rsp.data_out = row_mem[p - 1][col];
         end
         CMD_CLEAR: begin
            rows_held_now = 0;
            foreach (staged_row[j]) staged_row[j] = '0;
         end
         default: begin
         end
      endcase
      rsp.row_count = count_type'(rows_held_now);
      return rsp;
   endfunction

   task automatic send_command(cmd_type cmd, pos_type pos, col_type col, value_type val);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.cmd = cmd;
      req_if.position = pos;
      req_if.column = col;
      req_if.value = val;
      req_if.valid = 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_responses.push_back(predict_response(cmd, pos, col, val));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_columns(cfg_type cols);
      int nc;
      bit need_clear;
      nc = (cols > COLS) ? COLS : int'(cols);
      need_clear = 1'b0;
      for (int r = 0; r < rows_held_now; r++) begin
         for (int c = 0; c < nc; c++) begin
            if (!row_defined[r][c]) need_clear = 1'b1;
         end
      end
      wait_idle();
      if (need_clear) begin
         send_command(CMD_CLEAR, rand_pos(), rand_col(), rand_value());
         wait_idle();
      end
      @(negedge clock);
      csr_if.columns_in_use = cols;
      csr_if.valid = 1'b1;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      cols_setting = cols;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic test_empty_table();
      send_command(CMD_AVERAGE, rand_pos(), rand_col(), rand_value());
      send_command(CMD_DELETE, 6'd1, rand_col(), rand_value());
      send_command(CMD_SEARCH, rand_pos(), rand_col(), '0);
      send_command(CMD_READ, 6'd1, 5'd0, rand_value());
      send_command(CMD_INSERT, 6'd0, rand_col(), rand_value());
      send_command(CMD_INSERT, 6'd2, rand_col(), rand_value());
      send_command(CMD_UNUSED, 6'd63, 5'd31, '1);
   endtask

   task automatic test_element_extremes();
      write_columns(6'd2);
      send_command(CMD_STAGE, 6'd0, 5'd0, 32'sh7fffffff);
      send_command(CMD_STAGE, 6'd63, 5'd31, '1);
      send_command(CMD_STAGE, 6'd0, 5'd1, 32'sh80000000);
      send_command(CMD_INSERT, 6'd1, 5'd0, '0);
      send_command(CMD_STAGE, 6'd0, 5'd0, -32'sd5);
      send_command(CMD_STAGE, 6'd0, 5'd1, '0);
      send_command(CMD_INSERT, 6'd1, 5'd31, '1);
      send_command(CMD_READ, 6'd2, 5'd0, '0);
      send_command(CMD_READ, 6'd2, 5'd1, '0);
      send_command(CMD_READ, 6'd1, 5'd2, '0);
      send_command(CMD_READ, 6'd63, 5'd0, '0);
      send_command(CMD_SEARCH, 6'd0, 5'd0, 32'sh80000000);
      send_command(CMD_SEARCH, 6'd0, 5'd0, 32'sd12345);
      send_command(CMD_AVERAGE, 6'd0, 5'd0, '0);
      send_command(CMD_INSERT, 6'd4, 5'd0, '0);
      send_command(CMD_DELETE, 6'd3, 5'd0, '0);
      send_command(CMD_DELETE, 6'd1, 5'd0, '0);
      send_command(CMD_CLEAR, 6'd0, 5'd0, '0);
      send_command(CMD_READ, 6'd1, 5'd0, '0);
   endtask

   task automatic run_random_phase(cfg_type cols, int n_items, int insert_weight);
      int sent;
      int nc;
      int pick;
      cmd_type cmd;
      pos_type pos;
      col_type col;
      value_type val;
      write_columns(cols);
      nc = active_cols();
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 29) == 0) quiet = !quiet;
         pos = rand_pos();
         col = rand_col();
         val = rand_value();
         pick = $urandom_range(0, 99);
         if (pick < insert_weight) begin
            for (int c = 0; c < nc; c++) begin
               send_command(CMD_STAGE, rand_pos(), col_type'(c), rand_value());
               sent++;
            end
            if ($urandom_range(0, 9) != 0) pos = pos_type'($urandom_range(1, rows_held_now + 1));
            send_command(CMD_INSERT, pos, col, val);
            sent++;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               cmd = CMD_DELETE;
               if (rows_held_now != 0 && $urandom_range(0, 6) != 0)
                  pos = pos_type'($urandom_range(1, rows_held_now));
            end else if (pick < 50) begin
               cmd = CMD_SEARCH;
               if (rows_held_now != 0 && nc != 0 && $urandom_range(0, 9) < 7)
                  val = row_mem[$urandom_range(0, rows_held_now - 1)][$urandom_range(0, nc - 1)];
            end else if (pick < 62) begin
               cmd = CMD_AVERAGE;
            end else if (pick < 82) begin
               cmd = CMD_READ;
               if (rows_held_now != 0 && nc != 0 && $urandom_range(0, 4) != 0) begin
                  pos = pos_type'($urandom_range(1, rows_held_now));
                  col = col_type'($urandom_range(0, nc - 1));
               end
            end else if (pick < 90) begin
               cmd = CMD_STAGE;
            end else if (pick < 95) begin
               cmd = CMD_CLEAR;
            end else begin
               cmd = CMD_UNUSED;
            end
            send_command(cmd, pos, col, val);
            sent++;
         end
      end
      quiet = 1'b0;
   endtask

   task automatic test_random_traffic();
      run_random_phase(6'd4, 70, 45);
      run_random_phase(6'd1, 130, 65);
      run_random_phase(6'd32, 30, 45);
      run_random_phase(6'd0, 60, 65);
      run_random_phase(6'd2, 60, 45);
      run_random_phase(6'd63, 25, 45);
      run_random_phase(6'd7, 50, 45);
      run_random_phase(6'd33, 25, 45);
      run_random_phase(6'd3, 50, 45);
      run_random_phase(6'd16, 40, 45);
   endtask

   initial begin
      int stall;
      stall = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_if.ready = 1'b0;
            stall--;
         end else begin
            rsp_if.ready = 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : check_responses
      response_type want;
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_responses.size() == 0) begin
            $error("Response transaction arrived with no command outstanding.");
            fail_count++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
               fail_count++;
            end
            if (rsp_if.found_row !== want.found_row) begin
               $error("found_row: expected %0d, actual %0d", want.found_row, rsp_if.found_row);
               fail_count++;
            end
            if (rsp_if.found_column !== want.found_column) begin
               $error("found_column: expected %0d, actual %0d", want.found_column,
                      rsp_if.found_column);
               fail_count++;
            end
            if (rsp_if.data_out !== want.data_out) begin
               $error("data_out: expected %0d, actual %0d", want.data_out, rsp_if.data_out);
               fail_count++;
            end
            if (rsp_if.row_count !== want.row_count) begin
               $error("row_count: expected %0d, actual %0d", want.row_count, rsp_if.row_count);
               fail_count++;
            end
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.cmd = CMD_STAGE;
      req_if.position = '0;
      req_if.column = '0;
      req_if.value = '0;
      csr_if.valid = 1'b0;
      csr_if.columns_in_use = COLS_RESET;
      foreach (staged_row[j]) staged_row[j] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_table();
      test_element_extremes();
      test_random_traffic();
      wait_idle();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/rtis_pkg.sv
hdl/rtis_if.sv
hdl/rtis_div.sv
hdl/row_table_insert_delete_search.sv
hdl/rtis_chk.sv
tb/sv/tb_row_table_insert_delete_search.sv
